FILE: src/mh_pkg.sv
// Shared types, widths and the arctangent table for the compass heading block.
package mh_pkg;

  // Fixed-point layout of the rotation datapath
  localparam int AXIS_W    = 16;
  localparam int FRAC_W    = 16;                    // axis scaled by 2^16
  localparam int XY_W      = AXIS_W + 1 + FRAC_W + 4;
  localparam int ACC_FRAC  = 20;                    // angle fraction bits
  localparam int ACC_W     = 28;                    // signed angle accumulator
  localparam int HSUM_W    = 31;                    // base plus accumulator
  localparam int H_W       = 29;                    // clamped heading, unsigned
  localparam int HEAD_W    = 16;
  localparam int MAX_STAGES = 24;
  localparam int IDX_W     = 5;

  localparam logic [H_W-1:0] DEG180_Q = H_W'(180) << ACC_FRAC;
  localparam logic [H_W-1:0] DEG360_Q = H_W'(360) << ACC_FRAC;

  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_HALF = 2'd1,
    BASE_FULL = 2'd2
  } base_sel_t;

  // One vector travelling down the row of rotation cells
  typedef struct packed {
    logic                     skip;   // Y reads zero: the rotation angle is not added
    base_sel_t                base;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [ACC_W-1:0]  z;
    logic signed [AXIS_W-1:0] fx;
    logic signed [AXIS_W-1:0] fy;
    logic signed [AXIS_W-1:0] fz;
  } mh_vec_t;

  // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_q20(input logic [IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = 28'sd47185920;
      5'd1:    v = 28'sd27855475;
      5'd2:    v = 28'sd14718068;
      5'd3:    v = 28'sd7471121;
      5'd4:    v = 28'sd3750058;
      5'd5:    v = 28'sd1876857;
      5'd6:    v = 28'sd938658;
      5'd7:    v = 28'sd469357;
      5'd8:    v = 28'sd234682;
      5'd9:    v = 28'sd117342;
      5'd10:   v = 28'sd58671;
      5'd11:   v = 28'sd29335;
      5'd12:   v = 28'sd14668;
      5'd13:   v = 28'sd7334;
      5'd14:   v = 28'sd3667;
      5'd15:   v = 28'sd1833;
      5'd16:   v = 28'sd917;
      5'd17:   v = 28'sd458;
      5'd18:   v = 28'sd229;
      5'd19:   v = 28'sd115;
      5'd20:   v = 28'sd57;
      5'd21:   v = 28'sd29;
      5'd22:   v = 28'sd14;
      5'd23:   v = 28'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/mh_prep.sv
// Frame assembly and half-plane fold ahead of the rotation cells.
module mh_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  logic [7:0]       x_hi_i,
  input  logic [7:0]       x_lo_i,
  input  logic [7:0]       z_hi_i,
  input  logic [7:0]       z_lo_i,
  input  logic [7:0]       y_hi_i,
  input  logic [7:0]       y_lo_i,
  output logic             valid_o,
  output mh_pkg::mh_vec_t  vec_o
);
  import mh_pkg::*;

  logic signed [AXIS_W-1:0] ax, ay, az;
  logic signed [AXIS_W:0]   xf, yf;
  mh_vec_t                  vec_nxt, vec_r;
  logic                     valid_r;

  always_comb begin
    ax = {x_hi_i, x_lo_i};
    ay = {y_hi_i, y_lo_i};
    az = {z_hi_i, z_lo_i};
    vec_nxt = '0;
    // Turn a vector in the left half-plane by 180 degrees
    if (ax[AXIS_W-1]) begin
      xf = -(AXIS_W+1)'(ax);
      yf = -(AXIS_W+1)'(ay);
      vec_nxt.base = ay[AXIS_W-1] ? BASE_ZERO : BASE_FULL;
    end else begin
      xf = (AXIS_W+1)'(ax);
      yf = (AXIS_W+1)'(ay);
      vec_nxt.base = BASE_HALF;
    end
    vec_nxt.skip = (ay == '0);
    vec_nxt.x    = {{(XY_W-AXIS_W-1-FRAC_W){xf[AXIS_W]}}, xf, {FRAC_W{1'b0}}};
    vec_nxt.y    = {{(XY_W-AXIS_W-1-FRAC_W){yf[AXIS_W]}}, yf, {FRAC_W{1'b0}}};
    vec_nxt.z    = '0;
    vec_nxt.fx   = ax;
    vec_nxt.fy   = ay;
    vec_nxt.fz   = az;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc_i;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;

endmodule

FILE: src/mh_cell.sv
// One CORDIC vectoring cell: a single micro-rotation and its register.
module mh_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  mh_pkg::mh_vec_t  vec_i,
  output logic             valid_o,
  output mh_pkg::mh_vec_t  vec_o
);
  import mh_pkg::*;

  localparam logic signed [ACC_W-1:0] ATAN = atan_q20(IDX_W'(STAGE_IDX));

  logic signed [XY_W-1:0] dx, dy;
  mh_vec_t                vec_nxt, vec_r;
  logic                   valid_r;

  always_comb begin
    dx      = vec_i.y >>> STAGE_IDX;
    dy      = vec_i.x >>> STAGE_IDX;
    vec_nxt = vec_i;
    // Drive Y towards zero
    if (!vec_i.y[XY_W-1]) begin
      vec_nxt.x = vec_i.x + dx;
      vec_nxt.y = vec_i.y - dy;
      vec_nxt.z = vec_i.z + ATAN;
    end else begin
      vec_nxt.x = vec_i.x - dx;
      vec_nxt.y = vec_i.y + dy;
      vec_nxt.z = vec_i.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;

endmodule

FILE: src/mh_finish.sv
// Heading assembly: add the base angle, limit to 0..360, round and saturate.
module mh_finish #(
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  mh_pkg::mh_vec_t             vec_i,
  output logic                        valid_o,
  output logic signed [15:0]          fx_o,
  output logic signed [15:0]          fy_o,
  output logic signed [15:0]          fz_o,
  output logic [15:0]                 head_o
);
  import mh_pkg::*;

  localparam int SH = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam int RW = H_W + 1;
  localparam logic [RW-1:0] RND = RW'(1) << (SH - 1);

  logic signed [HSUM_W-1:0] base_q, hsum;
  logic [H_W-1:0]           h_nxt, h_r;
  logic [RW-1:0]            r;
  logic [HEAD_W-1:0]        head_nxt, head_r;
  logic signed [AXIS_W-1:0] fx_r, fy_r, fz_r, fx2_r, fy2_r, fz2_r;
  logic                     v1_r, v2_r;

  // First step: base plus accumulated angle unless skip, limited to circle
  always_comb begin
    unique case (vec_i.base)
      BASE_ZERO: base_q = '0;
      BASE_HALF: base_q = HSUM_W'(DEG180_Q);
      BASE_FULL: base_q = HSUM_W'(DEG360_Q);
      default:   base_q = '0;
    endcase
    hsum = vec_i.skip ? base_q : base_q + HSUM_W'(vec_i.z);
    if (hsum[HSUM_W-1]) begin
      h_nxt = '0;
    end else if (hsum > HSUM_W'(DEG360_Q)) begin
      h_nxt = DEG360_Q;
    end else begin
      h_nxt = hsum[H_W-1:0];
    end
  end

  // Second step: round half up, then saturate to the output width
  always_comb begin
    r = (RW'(h_r) + RND) >> SH;
    if (r[RW-1:HEAD_W] != '0) begin
      head_nxt = '1;
    end else begin
      head_nxt = r[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    fx_r   <= vec_i.fx;
    fy_r   <= vec_i.fy;
    fz_r   <= vec_i.fz;
    head_r <= head_nxt;
    fx2_r  <= fx_r;
    fy2_r  <= fy_r;
    fz2_r  <= fz_r;
  end

  assign valid_o = v2_r;
  assign fx_o    = fx2_r;
  assign fy_o    = fy2_r;
  assign fz_o    = fz2_r;
  assign head_o  = head_r;

endmodule

FILE: src/magnetometer_heading.sv
// Top level of the compass heading block: frame in, axis readings and heading out.
//
// Takes one six-byte magnetometer frame (X, Z, Y, high byte first) per
// transaction and returns the three signed axis readings with the heading
// atan2(Y, X) + 180 degrees, unsigned, ANGLE_FRACTION_BITS fraction bits,
// limited to 0..360. A frame may be started in every clock cycle: busy is
// always low. Each result appears on the out_ ports for one cycle with
// out_valid high, once its frame has passed the frame assembly register, the
// register of each rotation cell, the base add and limit register and the
// rounding register. The receiver cannot stall the block, so it must take every
// transaction as it comes; results keep the order of the frames.
module magnetometer_heading #(
  parameter int CORDIC_STAGES       = 16,
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_x_high_byte,
  input  logic [7:0]  in_x_low_byte,
  input  logic [7:0]  in_z_high_byte,
  input  logic [7:0]  in_z_low_byte,
  input  logic [7:0]  in_y_high_byte,
  input  logic [7:0]  in_y_low_byte,
  output logic        out_valid,
  output logic signed [15:0] out_field_x,
  output logic signed [15:0] out_field_y,
  output logic signed [15:0] out_field_z,
  output logic [15:0] out_heading_q7
);
  import mh_pkg::*;

  // The pipeline never holds, so a new frame is always welcome
  assign busy = 1'b0;

  logic    valid_c [0:CORDIC_STAGES];
  mh_vec_t vec_c   [0:CORDIC_STAGES];

  // Assemble the axes and fold the left half-plane
  mh_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (start && !busy),
    .x_hi_i  (in_x_high_byte),
    .x_lo_i  (in_x_low_byte),
    .z_hi_i  (in_z_high_byte),
    .z_lo_i  (in_z_low_byte),
    .y_hi_i  (in_y_high_byte),
    .y_lo_i  (in_y_low_byte),
    .valid_o (valid_c[0]),
    .vec_o   (vec_c[0])
  );

  // Row of rotation cells; each advances its vector one cell per cycle
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    mh_cell #(
      .STAGE_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[g]),
      .vec_i   (vec_c[g]),
      .valid_o (valid_c[g+1]),
      .vec_o   (vec_c[g+1])
    );
  end

  // Add the base angle, limit, round and register the result
  mh_finish #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_c[CORDIC_STAGES]),
    .vec_i   (vec_c[CORDIC_STAGES]),
    .valid_o (out_valid),
    .fx_o    (out_field_x),
    .fy_o    (out_field_y),
    .fz_o    (out_field_z),
    .head_o  (out_heading_q7)
  );

endmodule

FILE: bench/magnetometer_heading_tb.sv
// Testbench for magnetometer_heading: frame assembly and CORDIC heading against a bit-true predictor.
module magnetometer_heading_tb;

  // Keep these in step with the parameters given to the instance below
  localparam int ROT_STAGES   = 16;
  localparam int HEAD_FRAC    = 7;
  localparam int ANGLE_FRAC   = 20;             // fraction bits of the angle sum
  localparam int LATENCY      = ROT_STAGES + 3; // start to out_valid, in cycles
  localparam int DRAIN_LIMIT  = 40 * LATENCY;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    logic [15:0]        heading;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_x_high_byte = '0;
  logic [7:0]  in_x_low_byte = '0;
  logic [7:0]  in_z_high_byte = '0;
  logic [7:0]  in_z_low_byte = '0;
  logic [7:0]  in_y_high_byte = '0;
  logic [7:0]  in_y_low_byte = '0;
  logic        out_valid;
  logic signed [15:0] out_field_x;
  logic signed [15:0] out_field_y;
  logic signed [15:0] out_field_z;
  logic [15:0] out_heading_q7;

  reading_t pending_readings[$];   // predicted results, oldest first
  int       mismatch_count = 0;
  bit       back_to_back = 1'b0;   // when set, the sender leaves no gaps

  magnetometer_heading #(
    .CORDIC_STAGES       (ROT_STAGES),
    .ANGLE_FRACTION_BITS (HEAD_FRAC)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_high_byte (in_x_high_byte),
    .in_x_low_byte  (in_x_low_byte),
    .in_z_high_byte (in_z_high_byte),
    .in_z_low_byte  (in_z_low_byte),
    .in_y_high_byte (in_y_high_byte),
    .in_y_low_byte  (in_y_low_byte),
    .out_valid      (out_valid),
    .out_field_x    (out_field_x),
    .out_field_y    (out_field_y),
    .out_field_z    (out_field_z),
    .out_heading_q7 (out_heading_q7)
  );

  always #1 clk = ~clk;

  // Rotation angle of stage i: atan(2^-i) in degrees, 20 fraction bits, nearest
  function automatic longint rotation_angle(input int stage);
    case (stage)
      0:  return 47185920;
      1:  return 27855475;
      2:  return 14718068;
      3:  return 7471121;
      4:  return 3750058;
      5:  return 1876857;
      6:  return 938658;
      7:  return 469357;
      8:  return 234682;
      9:  return 117342;
      10: return 58671;
      11: return 29335;
      12: return 14668;
      13: return 7334;
      14: return 3667;
      15: return 1833;
      16: return 917;
      17: return 458;
      18: return 229;
      19: return 115;
      20: return 57;
      21: return 29;
      22: return 14;
      23: return 7;
      default: return 0;
    endcase
  endfunction

  // Heading in degrees plus 180, HEAD_FRAC fraction bits, as the block forms it
  function automatic logic [15:0] predict_heading(input logic signed [15:0] ax,
                                                  input logic signed [15:0] ay);
    longint vx, vy, acc, sum, rounded, dx, dy, base_deg;
    int     i;
    vx  = ax;
    vy  = ay;
    acc = 0;
    // Undefined direction: report due south, i.e. 180
    if (vx == 0 && vy == 0)
      return 16'(180 << HEAD_FRAC);
    // Fold the left half-plane onto the right one and move the base to match
    if (vx < 0) begin
      base_deg = (ay >= 0) ? 360 : 0;
      vx = -vx;
      vy = -vy;
    end else begin
      base_deg = 180;
    end
    if (vy != 0) begin
      vx = vx * 65536;
      vy = vy * 65536;
      for (i = 0; i < ROT_STAGES; i++) begin
        // Arithmetic shifts on longint round toward minus infinity
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx  = vx + dx;
          vy  = vy - dy;
          acc = acc + rotation_angle(i);
        end else begin
          vx  = vx - dx;
          vy  = vy + dy;
          acc = acc - rotation_angle(i);
        end
      end
    end
    sum = (base_deg << ANGLE_FRAC) + acc;
    // Limit the residual error of the rotations to 0..360
    if (sum < 0)
      sum = 0;
    if (sum > (longint'(360) << ANGLE_FRAC))
      sum = longint'(360) << ANGLE_FRAC;
    rounded = (sum + (longint'(1) << (ANGLE_FRAC - HEAD_FRAC - 1)))
              >>> (ANGLE_FRAC - HEAD_FRAC);
    if (rounded > 65535)
      rounded = 65535;
    return rounded[15:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
  endtask

  // Offer one frame; return once the block has taken the transaction
  task automatic send_frame(input logic signed [15:0] fx, input logic signed [15:0] fy,
                            input logic signed [15:0] fz);
    int       gap;
    reading_t want;
    gap = back_to_back ? 0 : $urandom_range(0, 7);
    // Drop start for the gap and put junk on the bytes so that idle data is ignored
    if (gap > 0) begin
      start          <= 1'b0;
      in_x_high_byte <= 8'($urandom);
      in_x_low_byte  <= 8'($urandom);
      in_z_high_byte <= 8'($urandom);
      in_z_low_byte  <= 8'($urandom);
      in_y_high_byte <= 8'($urandom);
      in_y_low_byte  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_x_high_byte <= fx[15:8];
    in_x_low_byte  <= fx[7:0];
    in_z_high_byte <= fz[15:8];
    in_z_low_byte  <= fz[7:0];
    in_y_high_byte <= fy[15:8];
    in_y_low_byte  <= fy[7:0];
    want.fx      = fx;
    want.fy      = fy;
    want.fz      = fz;
    want.heading = predict_heading(fx, fy);
    // Hold the frame until an edge sees start high with busy low
    do @(posedge clk); while (busy !== 1'b0);
    pending_readings.push_back(want);
  endtask

  // Every strobed result is a transaction the receiver must take at once
  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_readings.size() == 0) begin
        note_mismatch("unexpected result, heading", 16'hxxxx, out_heading_q7);
      end else begin
        want = pending_readings.pop_front();
        if (out_valid !== 1'b1)
          note_mismatch("out_valid", 16'h0001, {15'd0, out_valid});
        if (out_field_x !== want.fx)
          note_mismatch("field_x", want.fx, out_field_x);
        if (out_field_y !== want.fy)
          note_mismatch("field_y", want.fy, out_field_y);
        if (out_field_z !== want.fz)
          note_mismatch("field_z", want.fz, out_field_z);
        if (out_heading_q7 !== want.heading)
          note_mismatch("heading_q7", want.heading, out_heading_q7);
      end
    end
  end

  // Full-scale values and byte patterns on all three axes
  task automatic test_axis_extremes();
    send_frame(16'sh0000, 16'sh0000, 16'sh0000);
    send_frame(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000, 16'sh8000);
    send_frame(16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_frame(16'sh00FF, 16'shFF00, 16'sh8000);
    send_frame(16'shFF00, 16'sh00FF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh7FFF, 16'sh0001);
  endtask

  // Zero axes, on-axis vectors, the left half-plane and headings that need limiting
  task automatic test_heading_special_cases();
    send_frame(16'sh0000, 16'sh0000, 16'sh1234);
    send_frame(16'sh0001, 16'sh0000, 16'sh0000);
    send_frame(16'sh7FFF, 16'sh0000, 16'sh0000);
    send_frame(-16'sh0001, 16'sh0000, 16'sh0000);
    send_frame(16'sh8000, 16'sh0000, 16'sh0000);
    send_frame(16'sh0000, 16'sh0001, 16'sh0000);
    send_frame(16'sh0000, -16'sh0001, 16'sh0000);
    send_frame(-16'sh0005, 16'sh0003, 16'sh0000);
    send_frame(-16'sh0005, -16'sh0003, 16'sh0000);
    // Just either side of the X axis: on the negative side the sum lands at the range ends
    send_frame(16'sh8000, 16'sh0001, 16'sh0000);
    send_frame(16'sh8000, -16'sh0001, 16'sh0000);
    send_frame(16'sh7FFF, 16'sh0001, 16'sh0000);
    send_frame(16'sh7FFF, -16'sh0001, 16'sh0000);
    send_frame(-16'sh0001, 16'sh0001, 16'sh0000);
  endtask

  // Wide random sweep, weighted toward small vectors, near-axis and diagonal directions
  task automatic test_random_frames(input int count);
    logic signed [15:0] fx, fy, fz;
    int n;
    for (n = 0; n < count; n++) begin
      // Switch between gapped and back-to-back stretches now and then
      if (n % 40 == 0)
        back_to_back = ($urandom_range(0, 3) == 0);
      fz = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          fx = 16'($urandom);
          fy = 16'($urandom);
        end
        5, 6: begin
          fx = 16'(int'($urandom_range(0, 128)) - 64);
          fy = 16'(int'($urandom_range(0, 128)) - 64);
        end
        7: begin
          fx = 16'($urandom);
          fy = 16'(int'($urandom_range(0, 8)) - 4);
        end
        8: begin
          fx = 16'(int'($urandom_range(0, 8)) - 4);
          fy = 16'($urandom);
        end
        default: begin
          fx = 16'($urandom);
          fy = $urandom_range(0, 1) ? fx : -fx;
        end
      endcase
      send_frame(fx, fy, fz);
    end
    back_to_back = 1'b0;
  endtask

  // Release start, then wait for the pipeline to empty and settle
  task automatic drain_results();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_readings.size() != 0) begin
      mismatch_count += pending_readings.size();
      $display("%0t: %0d results never arrived", $time, pending_readings.size());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_axis_extremes();
    test_heading_special_cases();
    test_random_frames(RANDOM_ITEMS);
    drain_results();
    if (mismatch_count == 0)
      $display("magnetometer_heading: match");
    else
      $display("magnetometer_heading: mismatch");
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("magnetometer_heading: mismatch");
    $finish;
  end

endmodule

FILE: files.f
src/mh_pkg.sv
src/mh_prep.sv
src/mh_cell.sv
src/mh_finish.sv
src/magnetometer_heading.sv
bench/magnetometer_heading_tb.sv
